// ----- hdl/swfd_pkg.sv -----
// shared types and constants of the sync word frame deframer
package swfd_pkg;

  localparam int BYTE_W = 8;
  localparam int ADDR_W = 48;
  localparam int PHASE_W = 3;
  localparam int CFG_IDX_W = 2;

  // parse phase codes
  localparam logic [PHASE_W-1:0] PH_START1 = 3'd0;
  localparam logic [PHASE_W-1:0] PH_START2 = 3'd1;
  localparam logic [PHASE_W-1:0] PH_START3 = 3'd2;
  localparam logic [PHASE_W-1:0] PH_ADDR = 3'd3;
  localparam logic [PHASE_W-1:0] PH_LEN = 3'd4;
  localparam logic [PHASE_W-1:0] PH_PAYLOAD = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START_ONE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_TWO = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_THREE = 2'd2;

  // register reset values
  localparam logic [BYTE_W-1:0] START_ONE_RST = 8'd251;
  localparam logic [BYTE_W-1:0] START_TWO_RST = 8'd63;
  localparam logic [BYTE_W-1:0] START_THREE_RST = 8'd114;

  typedef struct packed {
    logic [BYTE_W-1:0] one;
    logic [BYTE_W-1:0] two;
    logic [BYTE_W-1:0] three;
  } swfd_sync_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic [ADDR_W-1:0] sender_address;
    logic [BYTE_W-1:0] frame_length;
    logic              last_byte;
    logic              empty_frame;
  } swfd_result_t;

endpackage

// ----- hdl/sync_word_frame_deframer.sv -----
// top level of the sync word frame deframer
// Takes one received byte per beat and, while the output is not stalled,
// sustains one byte per clock cycle: each accepted byte sits in an input
// register, the parser updates its phase in a single pass and, for payload
// bytes and empty frames, loads the output register as the byte leaves the
// input register. A stalled output keeps the byte in the input register
// and drops in_tready until the result beat is taken.
// Bytes of the start sequence, the address and a
// nonzero length give no output beat. Each output beat carries the payload
// byte, the six captured address bytes (first received most significant)
// and the length; out_tlast marks the final byte, and a zero length gives
// one beat with data zero, out_tlast high and out_tuser (empty) high.
// The user must set start bytes through the cfg port only while the stream is idle; the block does not enforce this.
module sync_word_frame_deframer #(
  parameter int ADDRESS_BYTES = 6
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [7:0] data_byte, [55:8] sender_address, [63:56] frame_length
  output logic        out_tlast,
  output logic [0:0]  out_tuser,  // [0] empty_frame
  input  logic        cfg_wen,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);
  import swfd_pkg::*;

  swfd_sync_t   sync_r;
  logic         s0_valid_r;
  logic [7:0]   s0_byte_r;
  logic         advance;
  logic         can_load;
  logic         res_valid;
  swfd_result_t res;
  swfd_result_t out_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r.one <= START_ONE_RST;
      sync_r.two <= START_TWO_RST;
      sync_r.three <= START_THREE_RST;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_START_ONE:   sync_r.one <= cfg_wdata;
        REG_START_TWO:   sync_r.two <= cfg_wdata;
        REG_START_THREE: sync_r.three <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register, drains whenever the output side can take a result
  assign advance = s0_valid_r && can_load;
  assign in_tready = !s0_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_tready) begin
      s0_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s0_byte_r <= in_tdata;
    end
  end

  swfd_parser #(
    .ADDRESS_BYTES(ADDRESS_BYTES)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .rx_byte   (s0_byte_r),
    .sync      (sync_r),
    .res_valid (res_valid),
    .res       (res)
  );

  swfd_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance),
    .load_valid (res_valid),
    .load_res   (res),
    .can_load   (can_load),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_res    (out_res)
  );

  assign out_tdata = {out_res.frame_length, out_res.sender_address, out_res.data_byte};
  assign out_tlast = out_res.last_byte;
  assign out_tuser = out_res.empty_frame;

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tlast && out_tdata[7:0] == 8'd0))
    else $error("empty frame beat not marked last with zero data");

  a_empty_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata[63:56] == 8'd0))
    else $error("empty frame beat with nonzero length");

  a_held_byte_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (s0_valid_r && out_tvalid && !out_tready) |=> (s0_valid_r && $stable(s0_byte_r)))
    else $error("pending input byte lost during output stall");

endmodule

// ----- hdl/swfd_parser.sv -----
// frame parser: phase state, address capture and payload counting
module swfd_parser #(
  parameter int ADDRESS_BYTES = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic [7:0]            rx_byte,
  input  swfd_pkg::swfd_sync_t  sync,
  output logic                  res_valid,
  output swfd_pkg::swfd_result_t res
);
  import swfd_pkg::*;

  localparam int CNT_W = (ADDRESS_BYTES > 1) ? $clog2(ADDRESS_BYTES) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ADDRESS_BYTES - 1);

  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [CNT_W-1:0]   addr_cnt_r, addr_cnt_nxt;
  logic [ADDR_W-1:0]  addr_r, addr_nxt;
  logic [BYTE_W-1:0]  len_r, len_nxt;
  logic [BYTE_W-1:0]  pay_cnt_r, pay_cnt_nxt;
  logic [BYTE_W-1:0]  pay_inc;
  logic [PHASE_W-1:0] hunt;

  assign hunt = (rx_byte == sync.one) ? PH_START2 : PH_START1;
  assign pay_inc = pay_cnt_r + 8'd1;

  always_comb begin
    phase_nxt = phase_r;
    addr_cnt_nxt = addr_cnt_r;
    addr_nxt = addr_r;
    len_nxt = len_r;
    pay_cnt_nxt = pay_cnt_r;
    res_valid = 1'b0;
    res.data_byte = rx_byte;
    res.sender_address = addr_r;
    res.frame_length = len_r;
    res.last_byte = 1'b0;
    res.empty_frame = 1'b0;
    case (phase_r)
      PH_START2: begin
        phase_nxt = (rx_byte == sync.two) ? PH_START3 : hunt;
      end
      PH_START3: begin
        if (rx_byte == sync.three) begin
          phase_nxt = PH_ADDR;
          addr_cnt_nxt = '0;
          addr_nxt = '0;
        end else begin
          phase_nxt = hunt;
        end
      end
      PH_ADDR: begin
        addr_nxt = {addr_r[ADDR_W-BYTE_W-1:0], rx_byte};
        if (addr_cnt_r == CNT_LAST) begin
          addr_cnt_nxt = '0;
          phase_nxt = PH_LEN;
        end else begin
          addr_cnt_nxt = addr_cnt_r + CNT_W'(1);
        end
      end
      PH_LEN: begin
        len_nxt = rx_byte;
        pay_cnt_nxt = '0;
        res.frame_length = rx_byte;
        if (rx_byte == '0) begin
          // zero length: one empty marker beat
          res_valid = 1'b1;
          res.data_byte = '0;
          res.last_byte = 1'b1;
          res.empty_frame = 1'b1;
          phase_nxt = PH_START1;
        end else begin
          phase_nxt = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        res_valid = 1'b1;
        res.last_byte = (pay_inc == len_r);
        pay_cnt_nxt = pay_inc;
        if (pay_inc == len_r) begin
          phase_nxt = PH_START1;
          pay_cnt_nxt = '0;
        end
      end
      default: begin
        phase_nxt = hunt;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START1;
      addr_cnt_r <= '0;
      addr_r <= '0;
      len_r <= '0;
      pay_cnt_r <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      addr_cnt_r <= addr_cnt_nxt;
      addr_r <= addr_nxt;
      len_r <= len_nxt;
      pay_cnt_r <= pay_cnt_nxt;
    end
  end

endmodule

// ----- hdl/swfd_out_reg.sv -----
// result register toward the output stream
module swfd_out_reg (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  logic                   load_valid,
  input  swfd_pkg::swfd_result_t load_res,
  output logic                   can_load,
  output logic                   out_valid,
  input  logic                   out_ready,
  output swfd_pkg::swfd_result_t out_res
);
  import swfd_pkg::*;

  logic         valid_r;
  swfd_result_t res_r;

  assign can_load = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= load_valid;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && load_valid) begin
      res_r <= load_res;
    end
  end

endmodule
